/* hdl/ofrl_pkg.sv */
`timescale 1ns / 1ps
package ofrl_pkg;

  localparam int RING_DEPTH   = 64;
  localparam int FRAME_BITS   = 64;
  localparam int COUNTER_BITS = 32;

  // fixed field widths of the request and result channels
  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 64;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 6;
  localparam int FILL_W  = 7;
  localparam int TOTAL_W = 32;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int DEST_W = SLOT_W + 1;
  localparam int RSUM_W = (DEST_W > IDX_W + 1) ? DEST_W : IDX_W + 1;
  localparam int ENTRY_W = FRAME_BITS + STAT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } ofrl_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_CLAMPED = 2'd1,
    ST_INVALID = 2'd2,
    ST_REFUSED = 2'd3
  } ofrl_status_e;

  typedef enum logic {
    S_IDLE,
    S_RD_WAIT
  } ofrl_state_e;

  typedef struct packed {
    logic take_item;
    logic load_read;
  } ofrl_cmd_t;

  typedef struct packed {
    logic is_read;
  } ofrl_sts_t;

  typedef struct packed {
    logic               accepted;
    logic               found;
    logic [DATA_W-1:0]  frame_out;
    logic [STAT_W-1:0]  status_out;
    logic [FILL_W-1:0]  fill_count;
    logic [TOTAL_W-1:0] overwritten_total;
    logic [TOTAL_W-1:0] rejected_total;
    logic [TOTAL_W-1:0] clamped_total;
    logic [TOTAL_W-1:0] invalid_total;
    logic               evidence_incomplete;
  } ofrl_res_t;

  function automatic logic [COUNTER_BITS-1:0] sat_bump(input logic [COUNTER_BITS-1:0] v);
    logic [COUNTER_BITS-1:0] r;
    r = (v == {COUNTER_BITS{1'b1}}) ? v : v + COUNTER_BITS'(1);
    return r;
  endfunction

endpackage

/* hdl/ofrl_if.sv */
`timescale 1ns / 1ps
interface ofrl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] frame_data;
  logic [1:0]  pack_status;
  logic [5:0]  read_index;

  modport source (output valid, func, frame_data, pack_status, read_index, input ready);
  modport sink (input valid, func, frame_data, pack_status, read_index, output ready);
endinterface

interface ofrl_res_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        found;
  logic [63:0] frame_out;
  logic [1:0]  status_out;
  logic [6:0]  fill_count;
  logic [31:0] overwritten_total;
  logic [31:0] rejected_total;
  logic [31:0] clamped_total;
  logic [31:0] invalid_total;
  logic        evidence_incomplete;

  modport source (output valid, accepted, found, frame_out, status_out, fill_count,
                  overwritten_total, rejected_total, clamped_total, invalid_total,
                  evidence_incomplete, input ready);
  modport sink (input valid, accepted, found, frame_out, status_out, fill_count,
                overwritten_total, rejected_total, clamped_total, invalid_total,
                evidence_incomplete, output ready);
endinterface

/* hdl/ofrl_ram.sv */
`timescale 1ns / 1ps
module ofrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ofrl_ctrl.sv */
`timescale 1ns / 1ps
module ofrl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ofrl_pkg::ofrl_sts_t sts_i,
  output ofrl_pkg::ofrl_cmd_t cmd_o
);
  import ofrl_pkg::*;

  ofrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = out_free;
        cmd_o.take_item = in_valid_i && out_free;
        if (cmd_o.take_item) begin
          if (sts_i.is_read) begin
            // data comes back from the store's registered read port in the next cycle
            state_d = S_RD_WAIT;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        if (out_free) begin
          cmd_o.load_read = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_WAIT) |-> !out_valid_q)
    else $error("result pending while a read is outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_item && sts_i.is_read) |=> (state_q == S_RD_WAIT))
    else $error("read request did not wait for store data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_read |=> (out_valid_q && state_q == S_IDLE))
    else $error("read result not presented");

endmodule

/* hdl/ofrl_dp.sv */
`timescale 1ns / 1ps
module ofrl_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          func_i,
  input  logic [63:0]         frame_data_i,
  input  logic [1:0]          pack_status_i,
  input  logic [5:0]          read_index_i,
  input  ofrl_pkg::ofrl_cmd_t cmd_i,
  output ofrl_pkg::ofrl_sts_t sts_o,
  output ofrl_pkg::ofrl_res_t res_o
);
  import ofrl_pkg::*;

  logic [SLOT_W-1:0]       oldest_q, oldest_d;
  logic [CNT_W-1:0]        held_q, held_d;
  logic [COUNTER_BITS-1:0] ovw_q, ovw_d, rej_q, rej_d, clp_q, clp_d, inv_q, inv_d;
  logic                    found_q;
  ofrl_res_t               res_q;

  logic                    is_app, is_read, is_clear, stat_ok, full, wr_en, rd_en, found;
  logic [DEST_W-1:0]       dest_sum;
  logic [SLOT_W-1:0]       dest_slot, rd_slot;
  logic [RSUM_W-1:0]       rd_sum;
  logic [ENTRY_W-1:0]      rd_entry;

  assign is_app   = (func_i == FUNC_APPEND);
  assign is_read  = (func_i == FUNC_READ);
  assign is_clear = (func_i == FUNC_CLEAR);
  assign stat_ok  = (pack_status_i != ST_REFUSED);
  assign full     = (held_q == CNT_W'(RING_DEPTH));
  assign sts_o.is_read = is_read;

  // write slot: oldest + held, below twice the depth
  always_comb begin
    dest_sum = DEST_W'(oldest_q) + DEST_W'(held_q);
    if (dest_sum >= DEST_W'(RING_DEPTH)) begin
      dest_sum = dest_sum - DEST_W'(RING_DEPTH);
    end
    dest_slot = dest_sum[SLOT_W-1:0];
  end

  // read slot only matters when found, then the sum stays below twice the depth
  always_comb begin
    found  = RSUM_W'(read_index_i) < RSUM_W'(held_q);
    rd_sum = RSUM_W'(oldest_q) + RSUM_W'(read_index_i);
    if (rd_sum >= RSUM_W'(RING_DEPTH)) begin
      rd_sum = rd_sum - RSUM_W'(RING_DEPTH);
    end
    rd_slot = rd_sum[SLOT_W-1:0];
  end

  assign wr_en = cmd_i.take_item && is_app && stat_ok;
  assign rd_en = cmd_i.take_item && is_read;

  ofrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (dest_slot),
    .wdata_i ({pack_status_i, frame_data_i[FRAME_BITS-1:0]}),
    .re_i    (rd_en),
    .raddr_i (rd_slot),
    .rdata_o (rd_entry)
  );

  always_comb begin
    oldest_d = oldest_q;
    held_d   = held_q;
    ovw_d    = ovw_q;
    rej_d    = rej_q;
    clp_d    = clp_q;
    inv_d    = inv_q;
    if (is_app) begin
      if (!stat_ok) begin
        rej_d = sat_bump(rej_q);
      end else begin
        if (full) begin
          oldest_d = (oldest_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : oldest_q + SLOT_W'(1);
          ovw_d    = sat_bump(ovw_q);
        end else begin
          held_d = held_q + CNT_W'(1);
        end
        if (pack_status_i == ST_CLAMPED) begin
          clp_d = sat_bump(clp_q);
        end
        if (pack_status_i == ST_INVALID) begin
          inv_d = sat_bump(inv_q);
        end
      end
    end else if (is_clear) begin
      oldest_d = '0;
      held_d   = '0;
      ovw_d    = '0;
      rej_d    = '0;
      clp_d    = '0;
      inv_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      held_q   <= '0;
      ovw_q    <= '0;
      rej_q    <= '0;
      clp_q    <= '0;
      inv_q    <= '0;
    end else if (cmd_i.take_item) begin
      oldest_q <= oldest_d;
      held_q   <= held_d;
      ovw_q    <= ovw_d;
      rej_q    <= rej_d;
      clp_q    <= clp_d;
      inv_q    <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      found_q <= found;
    end
    if (cmd_i.take_item && !is_read) begin
      res_q.accepted            <= is_app && stat_ok;
      res_q.found               <= 1'b0;
      res_q.frame_out           <= '0;
      res_q.status_out          <= '0;
      res_q.fill_count          <= FILL_W'(held_d);
      res_q.overwritten_total   <= TOTAL_W'(ovw_d);
      res_q.rejected_total      <= TOTAL_W'(rej_d);
      res_q.clamped_total       <= TOTAL_W'(clp_d);
      res_q.invalid_total       <= TOTAL_W'(inv_d);
      res_q.evidence_incomplete <= |{ovw_d, rej_d, clp_d, inv_d};
    end else if (cmd_i.load_read) begin
      res_q.accepted            <= 1'b0;
      res_q.found               <= found_q;
      res_q.frame_out           <= found_q ? DATA_W'(rd_entry[FRAME_BITS-1:0]) : '0;
      res_q.status_out          <= found_q ? rd_entry[ENTRY_W-1 -: STAT_W] : '0;
      res_q.fill_count          <= FILL_W'(held_q);
      res_q.overwritten_total   <= TOTAL_W'(ovw_q);
      res_q.rejected_total      <= TOTAL_W'(rej_q);
      res_q.clamped_total       <= TOTAL_W'(clp_q);
      res_q.invalid_total       <= TOTAL_W'(inv_q);
      res_q.evidence_incomplete <= |{ovw_q, rej_q, clp_q, inv_q};
    end
  end

  assign res_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(RING_DEPTH))
    else $error("fill count past ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_item && is_clear) |=> (held_q == '0 && oldest_q == '0 && ovw_q == '0))
    else $error("clear left state behind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_item && is_app && stat_ok && full) |=> (held_q == CNT_W'(RING_DEPTH)))
    else $error("overwrite changed the fill count");

endmodule

/* hdl/overwriting_frame_ring_log.sv */
// Results: append, clear and unused codes register theirs in the cycle after being taken;
//   a read passes the store's registered read port first. One non-read request per cycle
//   is taken unless results stall; a read blocks new requests until its result is loaded.
// Reset (async, active low) empties the ring and zeroes the counters; store contents
//   are not cleared and are reached only once written again.
`timescale 1ns / 1ps
module overwriting_frame_ring_log (
  input logic        clk_i,
  input logic        rst_ni,
  ofrl_req_if.sink   req_i,
  ofrl_res_if.source res_o
);
  import ofrl_pkg::*;

  ofrl_cmd_t cmd;
  ofrl_sts_t sts;
  ofrl_res_t res;

  ofrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ofrl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (req_i.func),
    .frame_data_i  (req_i.frame_data),
    .pack_status_i (req_i.pack_status),
    .read_index_i  (req_i.read_index),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_o         (res)
  );

  assign res_o.accepted            = res.accepted;
  assign res_o.found               = res.found;
  assign res_o.frame_out           = res.frame_out;
  assign res_o.status_out          = res.status_out;
  assign res_o.fill_count          = res.fill_count;
  assign res_o.overwritten_total   = res.overwritten_total;
  assign res_o.rejected_total      = res.rejected_total;
  assign res_o.clamped_total       = res.clamped_total;
  assign res_o.invalid_total       = res.invalid_total;
  assign res_o.evidence_incomplete = res.evidence_incomplete;

endmodule
